/* hdl/rsbk_pkg.sv */
package rsbk_pkg;

	localparam int MAX_RECORDS = 16;
	localparam int TEXT_BYTES  = 7;
	localparam int TEXT_W      = 8 * TEXT_BYTES;
	localparam int SCORE_W     = 7;
	localparam int IDX_W       = $clog2(MAX_RECORDS);
	localparam int CNT_W       = IDX_W + 1;

	localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(100);

	typedef struct packed {
		logic [TEXT_W-1:0]  key;
		logic [TEXT_W-1:0]  payload;
		logic [SCORE_W-1:0] score;
	} rec_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PASS_RD,
		ST_PASS_LATCH,
		ST_PASS_CMP,
		ST_PASS_WLAST,
		ST_EMIT_RD,
		ST_EMIT_SHOW
	} state_t;

endpackage

/* hdl/record_sort_by_key_top.sv */
// After the final request of a set, its n records are bubble-sorted, one compare/exchange
//   per cycle, each pass going through read, latch, compare and last-write states; then
//   each result is read from the store and shown until the output side takes it.
// Throughput: one load request per cycle while a set fills; no new requests are taken
//   while a set is being sorted and emitted.
// Reset: arst_n clears the sequencer and the record count; the record store is not cleared.
module record_sort_by_key_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rsbk_pkg::TEXT_W-1:0]   key_text,
	input  logic [rsbk_pkg::TEXT_W-1:0]   payload_text,
	input  logic [rsbk_pkg::SCORE_W-1:0]  score,
	input  logic                          final_record,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rsbk_pkg::TEXT_W-1:0]   sorted_key,
	output logic [rsbk_pkg::TEXT_W-1:0]   sorted_payload,
	output logic [rsbk_pkg::SCORE_W-1:0]  sorted_score,
	output logic                          end_of_set
);

	// Record store: one write port, one registered read port.
	rsbk_pkg::rec_t store_mem [rsbk_pkg::MAX_RECORDS];
	rsbk_pkg::rec_t rd_q;

	rsbk_pkg::state_t state_q, state_d;

	logic [rsbk_pkg::CNT_W-1:0] count_q;   // records in the current set
	logic [rsbk_pkg::CNT_W-1:0] k_q;       // emit position
	logic [rsbk_pkg::IDX_W-1:0] j_q;       // compare position within a pass
	logic [rsbk_pkg::IDX_W-1:0] last_q;    // last slot the current pass touches
	rsbk_pkg::rec_t             carry_q;   // largest record seen so far in the pass

	// Shared memory controls
	logic                       we;
	logic [rsbk_pkg::IDX_W-1:0] waddr;
	rsbk_pkg::rec_t             wdata;
	logic                       re;
	logic [rsbk_pkg::IDX_W-1:0] raddr;

	logic                       in_acc;
	logic                       out_acc;
	logic                       has_room;
	logic [rsbk_pkg::CNT_W-1:0] n_next;
	logic                       swap;
	logic                       pass_end;
	logic                       last_out;
	logic [rsbk_pkg::SCORE_W-1:0] score_sat;
	rsbk_pkg::rec_t             in_rec;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign has_room = count_q < rsbk_pkg::CNT_W'(rsbk_pkg::MAX_RECORDS);
	assign n_next   = has_room ? count_q + rsbk_pkg::CNT_W'(1) : count_q;

	// Saturate the score, then pack the incoming request.
	assign score_sat = (score > rsbk_pkg::SCORE_MAX) ? rsbk_pkg::SCORE_MAX : score;
	assign in_rec    = '{key: key_text, payload: payload_text, score: score_sat};

	// The one comparator: strictly greater moves the carried record on, so equal keys
	// keep their load order.
	assign swap     = carry_q.key > rd_q.key;
	assign pass_end = (j_q + rsbk_pkg::IDX_W'(1)) == last_q;
	assign last_out = k_q == (count_q - rsbk_pkg::CNT_W'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsbk_pkg::ST_LOAD: begin
				if (in_acc && final_record) begin
					state_d = (n_next == rsbk_pkg::CNT_W'(1)) ? rsbk_pkg::ST_EMIT_RD
						: rsbk_pkg::ST_PASS_RD;
				end
			end
			rsbk_pkg::ST_PASS_RD:    state_d = rsbk_pkg::ST_PASS_LATCH;
			rsbk_pkg::ST_PASS_LATCH: state_d = rsbk_pkg::ST_PASS_CMP;
			rsbk_pkg::ST_PASS_CMP: begin
				if (pass_end) state_d = rsbk_pkg::ST_PASS_WLAST;
			end
			rsbk_pkg::ST_PASS_WLAST: begin
				state_d = (last_q == rsbk_pkg::IDX_W'(1)) ? rsbk_pkg::ST_EMIT_RD
					: rsbk_pkg::ST_PASS_RD;
			end
			rsbk_pkg::ST_EMIT_RD:    state_d = rsbk_pkg::ST_EMIT_SHOW;
			rsbk_pkg::ST_EMIT_SHOW: begin
				if (out_acc) state_d = last_out ? rsbk_pkg::ST_LOAD : rsbk_pkg::ST_EMIT_RD;
			end
			default:                 state_d = rsbk_pkg::ST_LOAD;
		endcase
	end

	// Outputs and memory controls
	always_comb begin
		we        = 1'b0;
		waddr     = j_q;
		wdata     = carry_q;
		re        = 1'b0;
		raddr     = j_q + rsbk_pkg::IDX_W'(2);
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			rsbk_pkg::ST_LOAD: begin
				in_stall = 1'b0;
				// Drop a request that arrives with the store full.
				we    = in_acc && has_room;
				waddr = count_q[rsbk_pkg::IDX_W-1:0];
				wdata = in_rec;
			end
			rsbk_pkg::ST_PASS_RD: begin
				re    = 1'b1;
				raddr = '0;
			end
			rsbk_pkg::ST_PASS_LATCH: begin
				re    = 1'b1;
				raddr = rsbk_pkg::IDX_W'(1);
			end
			rsbk_pkg::ST_PASS_CMP: begin
				// Drop the smaller record behind, fetch the next one ahead.
				we    = 1'b1;
				waddr = j_q;
				wdata = swap ? rd_q : carry_q;
				re    = 1'b1;
			end
			rsbk_pkg::ST_PASS_WLAST: begin
				we    = 1'b1;
				waddr = last_q;
				wdata = carry_q;
			end
			rsbk_pkg::ST_EMIT_RD: begin
				re    = 1'b1;
				raddr = k_q[rsbk_pkg::IDX_W-1:0];
			end
			rsbk_pkg::ST_EMIT_SHOW: begin
				out_valid = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign sorted_key     = rd_q.key;
	assign sorted_payload = rd_q.payload;
	assign sorted_score   = rd_q.score;
	assign end_of_set     = last_out;

	// Store; read data only advances on a read, so a stalled result holds.
	always_ff @(posedge clk) begin
		if (we) store_mem[waddr] <= wdata;
		if (re) rd_q <= store_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == rsbk_pkg::ST_PASS_LATCH) begin
			carry_q <= rd_q;
		end else if (state_q == rsbk_pkg::ST_PASS_CMP && !swap) begin
			carry_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsbk_pkg::ST_LOAD;
			count_q <= '0;
			k_q     <= '0;
			j_q     <= '0;
			last_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				rsbk_pkg::ST_LOAD: begin
					if (in_acc) begin
						count_q <= n_next;
						k_q     <= '0;
						last_q  <= rsbk_pkg::IDX_W'(n_next - rsbk_pkg::CNT_W'(1));
					end
				end
				rsbk_pkg::ST_PASS_LATCH: j_q <= '0;
				rsbk_pkg::ST_PASS_CMP: begin
					if (!pass_end) j_q <= j_q + rsbk_pkg::IDX_W'(1);
				end
				rsbk_pkg::ST_PASS_WLAST: last_q <= last_q - rsbk_pkg::IDX_W'(1);
				rsbk_pkg::ST_EMIT_SHOW: begin
					if (out_acc) begin
						if (last_out) begin
							count_q <= '0;
						end else begin
							k_q <= k_q + rsbk_pkg::CNT_W'(1);
						end
					end
				end
				default: begin
					j_q <= j_q;
				end
			endcase
		end
	end

endmodule
